[rtl/lobm_pkg.sv]
package lobm_pkg;

    localparam int BOOK_SLOTS_DEF = 16;

    localparam logic [1:0] LIMIT      = 2'd0;
    localparam logic [1:0] MARKET     = 2'd1;
    localparam logic [1:0] CANCEL     = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic BUY  = 1'b0;
    localparam logic SELL = 1'b1;

    typedef enum logic [2:0] {
        K_ACCEPTED  = 3'd0,
        K_CANCELLED = 3'd1,
        K_REJECTED  = 3'd2,
        K_FILL      = 3'd3,
        K_BOOKFULL  = 3'd4
    } kind_t;

endpackage

[rtl/limit_order_book_matcher_unit.sv]
// channel  dir  handshake              word fields
// in       in   in_valid / in_ready    mode side order_ref price quantity
// out      out  out_valid / out_ready  kind owner_id fill_quantity fill_price
//                                      counterparty_id last
//
// one order at a time: in_ready is high only while the sequencer is idle
// a slot scan reads the slot memory one entry a cycle
// cancel: accept, one scan, a decide step, a closing step
// limit/market: accept, then per match one scan, a decide step and the taker
// and maker fill steps; a final scan and decide unless the last match fills the
// order; a closing step (zero quantity goes straight to closing)
// the newest word waits in a hold register until the next word or the end of
// the order settles its last flag; a cycle that moves a word stalls while
// hold and output registers are both full and out_ready is low
// reset clears the valid bits, arrival counter and word registers; slot
// contents stay undefined until written
module limit_order_book_matcher_unit #(
    parameter int BOOK_SLOTS = lobm_pkg::BOOK_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic        side,
    input  logic [31:0] order_ref,
    input  logic [31:0] price,
    input  logic [31:0] quantity,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [31:0] owner_id,
    output logic [31:0] fill_quantity,
    output logic [31:0] fill_price,
    output logic [31:0] counterparty_id,
    output logic        last
);
    import lobm_pkg::*;

    localparam int IW = (BOOK_SLOTS > 1) ? $clog2(BOOK_SLOTS) : 1;
    localparam int CW = IW + 1;
    localparam logic [CW-1:0] SLOTS_C  = CW'(BOOK_SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(BOOK_SLOTS - 1);

    typedef struct packed {
        logic        sd;
        logic [31:0] id;
        logic [31:0] px;
        logic [31:0] rem;
        logic [31:0] arr;
    } slot_t;

    typedef struct packed {
        kind_t       k;
        logic [31:0] owner;
        logic [31:0] qty;
        logic [31:0] px;
        logic [31:0] other;
    } word_t;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_FILL_T, S_FILL_M, S_DONE
    } state_t;

    // slot memory, one read port, one write port
    slot_t             mem [BOOK_SLOTS];
    slot_t             rd_reg;
    logic [IW-1:0]     raddr;
    logic              we;
    logic [IW-1:0]     waddr;
    slot_t             wdata;

    state_t                state_reg;
    logic [BOOK_SLOTS-1:0] valid_reg;
    logic [31:0]           arrival_reg;
    logic [1:0]            mode_reg;
    logic                  side_reg;
    logic [31:0]           id_reg, px_reg, qty_reg, f_reg;
    logic [CW-1:0]         cnt_reg;     // next address to read
    logic                  rv_reg;      // rd_reg holds entry ridx_reg
    logic [IW-1:0]         ridx_reg;
    logic                  found_reg;
    logic [IW-1:0]         best_reg;
    slot_t                 bestd_reg;
    logic                  hv_reg;      // hold register full
    word_t                 hold_reg;
    logic                  ov_reg;
    word_t                 out_reg;
    logic                  ol_reg;

    logic          hv_next;
    word_t         hold_next;
    logic          ov_next;
    word_t         out_next;
    logic          ol_next;

    logic          is_cancel;
    logic          entry_live;
    logic          better;
    logic          take;
    logic          px_ok;
    logic          decide_fill;
    logic          rest_go;
    logic [31:0]   fmin;
    logic          free_found;
    logic [IW-1:0] free_idx;
    logic          can_out;
    logic          emit_ok;
    logic          emit_go;
    logic          finish_go;
    word_t         emit_word;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    assign raddr      = (cnt_reg < SLOTS_C) ? cnt_reg[IW-1:0] : '0;
    assign is_cancel  = (mode_reg == CANCEL);
    assign entry_live = rv_reg && valid_reg[ridx_reg];

    // best price first (lowest ask for a buyer, highest bid for a seller), then oldest
    always_comb
    begin
        if (!found_reg)
            better = 1'b1;
        else if (rd_reg.px != bestd_reg.px)
            better = side_reg ? (rd_reg.px > bestd_reg.px) : (rd_reg.px < bestd_reg.px);
        else
            better = rd_reg.arr < bestd_reg.arr;
    end

    // cancel keeps the lowest matching index, matching keeps the best opposite order
    assign take = entry_live && (is_cancel ? (!found_reg && rd_reg.id == id_reg)
                                           : (rd_reg.sd != side_reg && better));

    assign fmin  = (qty_reg < bestd_reg.rem) ? qty_reg : bestd_reg.rem;
    assign px_ok = (mode_reg != LIMIT) ||
                   (side_reg == BUY ? bestd_reg.px <= px_reg : bestd_reg.px >= px_reg);
    assign decide_fill = found_reg && px_ok;

    // lowest free slot for a resting remainder
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = BOOK_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    assign rest_go = (state_reg == S_DECIDE) && !is_cancel && !decide_fill &&
                     (mode_reg == LIMIT) && free_found;

    assign can_out  = !ov_reg || out_ready;
    assign emit_ok  = !hv_reg || can_out;
    assign in_ready = (state_reg == S_IDLE);

    // word produced this cycle
    always_comb
    begin
        emit_go   = 1'b0;
        finish_go = 1'b0;
        emit_word = '{k: K_ACCEPTED, owner: id_reg, qty: '0, px: '0, other: '0};
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && mode != CANCEL)
                begin
                    emit_go         = 1'b1;
                    emit_word.owner = order_ref;
                    emit_word.k     = (mode inside {LIMIT, MARKET}) ? K_ACCEPTED : K_REJECTED;
                end
            end
            S_DECIDE:
            begin
                if (is_cancel)
                begin
                    emit_go     = emit_ok;
                    emit_word.k = found_reg ? K_CANCELLED : K_REJECTED;
                end
                else if (!decide_fill && mode_reg == LIMIT && !free_found)
                begin
                    emit_go     = emit_ok;
                    emit_word.k = K_BOOKFULL;
                end
            end
            S_FILL_T:
            begin
                emit_go   = emit_ok;
                emit_word = '{k: K_FILL, owner: id_reg, qty: f_reg, px: bestd_reg.px,
                              other: bestd_reg.id};
            end
            S_FILL_M:
            begin
                emit_go   = emit_ok;
                emit_word = '{k: K_FILL, owner: bestd_reg.id, qty: f_reg, px: bestd_reg.px,
                              other: id_reg};
            end
            S_DONE:
            begin
                finish_go = can_out;
            end
            default: ;
        endcase
    end

    // hold to output: a new word pushes the held one out with last low,
    // the end of the order pushes it out with last high
    always_comb
    begin
        hv_next   = hv_reg;
        hold_next = hold_reg;
        ov_next   = ov_reg && !out_ready;
        out_next  = out_reg;
        ol_next   = ol_reg;
        if (emit_go)
        begin
            if (hv_reg)
            begin
                ov_next  = 1'b1;
                out_next = hold_reg;
                ol_next  = 1'b0;
            end
            hv_next   = 1'b1;
            hold_next = emit_word;
        end
        if (finish_go)
        begin
            ov_next  = 1'b1;
            out_next = hold_reg;
            ol_next  = 1'b1;
            hv_next  = 1'b0;
        end
    end

    // single write port: maker remainder update or a new resting order
    always_comb
    begin
        we        = 1'b0;
        waddr     = best_reg;
        wdata     = bestd_reg;
        wdata.rem = bestd_reg.rem - f_reg;
        if (state_reg == S_FILL_M && emit_ok)
            we = 1'b1;
        else if (rest_go)
        begin
            we    = 1'b1;
            waddr = free_idx;
            wdata = '{sd: side_reg, id: id_reg, px: px_reg, rem: qty_reg, arr: arrival_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            arrival_reg <= '0;
            mode_reg    <= '0;
            side_reg    <= 1'b0;
            id_reg      <= '0;
            px_reg      <= '0;
            qty_reg     <= '0;
            f_reg       <= '0;
            cnt_reg     <= '0;
            rv_reg      <= 1'b0;
            ridx_reg    <= '0;
            found_reg   <= 1'b0;
            best_reg    <= '0;
            bestd_reg   <= '0;
            hv_reg      <= 1'b0;
            hold_reg    <= '0;
            ov_reg      <= 1'b0;
            out_reg     <= '0;
            ol_reg      <= 1'b0;
        end
        else
        begin
            hv_reg   <= hv_next;
            hold_reg <= hold_next;
            ov_reg   <= ov_next;
            out_reg  <= out_next;
            ol_reg   <= ol_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        mode_reg  <= mode;
                        side_reg  <= side;
                        id_reg    <= order_ref;
                        px_reg    <= price;
                        qty_reg   <= quantity;
                        cnt_reg   <= '0;
                        rv_reg    <= 1'b0;
                        found_reg <= 1'b0;
                        if (mode == CANCEL)
                            state_reg <= S_SCAN;
                        else if ((mode inside {LIMIT, MARKET}) && quantity != '0)
                            state_reg <= S_SCAN;
                        else
                            state_reg <= S_DONE;
                    end
                end
                S_SCAN:
                begin
                    if (cnt_reg < SLOTS_C)
                        cnt_reg <= cnt_reg + 1'b1;
                    rv_reg   <= (cnt_reg < SLOTS_C);
                    ridx_reg <= raddr;
                    if (take)
                    begin
                        found_reg <= 1'b1;
                        best_reg  <= ridx_reg;
                        bestd_reg <= rd_reg;
                    end
                    if (rv_reg && ridx_reg == LAST_IDX)
                        state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    if (is_cancel)
                    begin
                        if (emit_ok)
                        begin
                            if (found_reg)
                                valid_reg[best_reg] <= 1'b0;
                            state_reg <= S_DONE;
                        end
                    end
                    else if (decide_fill)
                    begin
                        f_reg     <= fmin;
                        state_reg <= S_FILL_T;
                    end
                    else if (rest_go)
                    begin
                        valid_reg[free_idx] <= 1'b1;
                        arrival_reg         <= arrival_reg + 1'b1;
                        state_reg           <= S_DONE;
                    end
                    else if (mode_reg == LIMIT)
                    begin
                        // book full: the remainder is dropped
                        if (emit_ok)
                            state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_DONE;
                end
                S_FILL_T:
                begin
                    if (emit_ok)
                        state_reg <= S_FILL_M;
                end
                S_FILL_M:
                begin
                    if (emit_ok)
                    begin
                        qty_reg <= qty_reg - f_reg;
                        if (bestd_reg.rem == f_reg)
                            valid_reg[best_reg] <= 1'b0;
                        if (qty_reg == f_reg)
                            state_reg <= S_DONE;
                        else
                        begin
                            cnt_reg   <= '0;
                            rv_reg    <= 1'b0;
                            found_reg <= 1'b0;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_DONE:
                begin
                    if (can_out)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid       = ov_reg;
    assign kind            = out_reg.k;
    assign owner_id        = out_reg.owner;
    assign fill_quantity   = out_reg.qty;
    assign fill_price      = out_reg.px;
    assign counterparty_id = out_reg.other;
    assign last            = ol_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("order accepted without effect");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid &&
            $stable({kind, owner_id, fill_quantity, fill_price, counterparty_id, last}))
        else $error("result word changed while waiting");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !hv_reg)
        else $error("word left in hold register");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == K_FILL) |-> (fill_quantity != '0))
        else $error("empty fill");
endmodule

[bench/tb_top.sv]
// scoreboard: predicts result words of the order book and checks them in order
class book_scoreboard;
    bit          live [lobm_pkg::BOOK_SLOTS_DEF];
    bit          s_side [lobm_pkg::BOOK_SLOTS_DEF];
    logic [31:0] s_id [lobm_pkg::BOOK_SLOTS_DEF];
    logic [31:0] s_px [lobm_pkg::BOOK_SLOTS_DEF];
    logic [31:0] s_rem [lobm_pkg::BOOK_SLOTS_DEF];
    logic [31:0] s_arr [lobm_pkg::BOOK_SLOTS_DEF];
    logic [31:0] stamp;
    logic [130:0] pending [$];
    bit lasts [$];
    int errors;
    int checked;

    function new();
        for (int i = 0; i < lobm_pkg::BOOK_SLOTS_DEF; i++) live[i] = 0;
        stamp = 0;
        errors = 0;
        checked = 0;
    endfunction

    function void push(logic [2:0] k, logic [31:0] o, logic [31:0] q, logic [31:0] p,
                       logic [31:0] c, bit l);
        pending.push_back({k, o, q, p, c});
        lasts.push_back(l);
    endfunction

    function int best_of(bit s);
        int b;
        bit better;
        b = -1;
        for (int i = 0; i < lobm_pkg::BOOK_SLOTS_DEF; i++) begin
            if (live[i] && s_side[i] == s) begin
                if (b < 0) b = i;
                else begin
                    if (s_px[i] != s_px[b])
                        better = (s == lobm_pkg::SELL) ? s_px[i] < s_px[b] : s_px[i] > s_px[b];
                    else
                        better = s_arr[i] < s_arr[b];
                    if (better) b = i;
                end
            end
        end
        return b;
    endfunction

    // queues the predicted result words of one accepted order
    function void note_order(logic [1:0] m, bit sd, logic [31:0] id, logic [31:0] px,
                             logic [31:0] qty);
        int b;
        int fs;
        logic [31:0] f;
        bit found;
        found = 0;
        if (m == lobm_pkg::CANCEL) begin
            for (int i = 0; i < lobm_pkg::BOOK_SLOTS_DEF; i++)
                if (!found && live[i] && s_id[i] == id) begin
                    live[i] = 0;
                    found = 1;
                end
            push(found ? lobm_pkg::K_CANCELLED : lobm_pkg::K_REJECTED, id, 0, 0, 0, 1);
            return;
        end
        if (m != lobm_pkg::LIMIT && m != lobm_pkg::MARKET) begin
            push(lobm_pkg::K_REJECTED, id, 0, 0, 0, 1);
            return;
        end
        push(lobm_pkg::K_ACCEPTED, id, 0, 0, 0, 0);
        while (qty > 0) begin
            b = best_of(~sd);
            if (b < 0) break;
            if (m == lobm_pkg::LIMIT && sd == lobm_pkg::BUY && s_px[b] > px) break;
            if (m == lobm_pkg::LIMIT && sd == lobm_pkg::SELL && s_px[b] < px) break;
            f = (qty < s_rem[b]) ? qty : s_rem[b];
            push(lobm_pkg::K_FILL, id, f, s_px[b], s_id[b], 0);
            push(lobm_pkg::K_FILL, s_id[b], f, s_px[b], id, 0);
            qty -= f;
            s_rem[b] -= f;
            if (s_rem[b] == 0) live[b] = 0;
        end
        if (m == lobm_pkg::LIMIT && qty > 0) begin
            fs = -1;
            for (int i = 0; i < lobm_pkg::BOOK_SLOTS_DEF; i++)
                if (fs < 0 && !live[i]) fs = i;
            if (fs < 0) begin
                push(lobm_pkg::K_BOOKFULL, id, 0, 0, 0, 0);
            end else begin
                live[fs] = 1;
                s_side[fs] = sd;
                s_id[fs] = id;
                s_px[fs] = px;
                s_rem[fs] = qty;
                s_arr[fs] = stamp;
                stamp++;
            end
        end
        void'(lasts.pop_back());
        lasts.push_back(1);
    endfunction

    function void check_word(logic [2:0] k, logic [31:0] o, logic [31:0] q, logic [31:0] p,
                             logic [31:0] c, logic l);
        logic [130:0] e;
        bit el;
        if (pending.size() == 0) begin
            $display("%0t: unexpected word kind=%0d owner=%h", $time, k, o);
            errors++;
            return;
        end
        e = pending.pop_front();
        el = lasts.pop_front();
        checked++;
        if (e[130:128] !== k) begin
            $display("%0t: kind exp %0d got %0d", $time, e[130:128], k); errors++;
        end
        if (e[127:96] !== o) begin
            $display("%0t: owner exp %h got %h", $time, e[127:96], o); errors++;
        end
        if (e[95:64] !== q) begin
            $display("%0t: fill_quantity exp %h got %h", $time, e[95:64], q); errors++;
        end
        if (e[63:32] !== p) begin
            $display("%0t: fill_price exp %h got %h", $time, e[63:32], p); errors++;
        end
        if (e[31:0] !== c) begin
            $display("%0t: counterparty exp %h got %h", $time, e[31:0], c); errors++;
        end
        if (el !== l) begin
            $display("%0t: last exp %0d got %0d", $time, el, l); errors++;
        end
    endfunction
endclass

module tb_top;
    import lobm_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic        side;
    logic [31:0] order_ref;
    logic [31:0] price;
    logic [31:0] quantity;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  kind;
    logic [31:0] owner_id;
    logic [31:0] fill_quantity;
    logic [31:0] fill_price;
    logic [31:0] counterparty_id;
    logic        last;

    // idle rates per phase, in percent
    int in_idle;
    int out_idle;
    int sent;
    logic [31:0] next_id;
    logic [31:0] live_ids [$];
    book_scoreboard sb;

    limit_order_book_matcher_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .side(side), .order_ref(order_ref), .price(price), .quantity(quantity),
        .out_valid(out_valid), .out_ready(out_ready),
        .kind(kind), .owner_id(owner_id), .fill_quantity(fill_quantity),
        .fill_price(fill_price), .counterparty_id(counterparty_id), .last(last)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // receiver: random ready, check every accepted word
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_word(kind, owner_id, fill_quantity, fill_price, counterparty_id, last);
        out_ready <= ($urandom_range(99) >= out_idle);
    end

    // drive one word and hold it until accepted; the scoreboard notes it on acceptance
    task send_order(logic [1:0] m, logic s, logic [31:0] id, logic [31:0] px,
                    logic [31:0] q);
        while ($urandom_range(99) < in_idle) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        mode <= m;
        side <= s;
        order_ref <= id;
        price <= px;
        quantity <= q;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_order(m, s, id, px, q);
        sent++;
    endtask

    // mostly well-formed orders on a narrow price band so they cross and rest
    task random_order();
        int r;
        logic [31:0] id;
        int k;
        r = $urandom_range(99);
        if (r < 20 && live_ids.size() > 0) begin
            k = $urandom_range(live_ids.size() - 1);
            id = live_ids[k];
            live_ids.delete(k);
            send_order(CANCEL, 1'($urandom), id, $urandom, $urandom);
        end else if (r < 25) begin
            // noise: unused mode, stale cancel, or wide fields
            send_order(2'($urandom_range(3)), 1'($urandom), $urandom, $urandom, $urandom);
        end else begin
            id = next_id;
            next_id++;
            if (r < 80) live_ids.push_back(id);
            if (live_ids.size() > 40) void'(live_ids.pop_front());
            send_order((r < 80) ? LIMIT : MARKET, 1'($urandom),
                       id, 32'd1000 + $urandom_range(8),
                       ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 20));
        end
    endtask

    task settle();
        in_valid <= 0;
        while (sb.pending.size() > 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        rst_n = 0;
        in_valid = 0;
        mode = 0;
        side = 0;
        order_ref = 0;
        price = 0;
        quantity = 0;
        sent = 0;
        next_id = 32'h100;
        in_idle = 29;
        out_idle = 75;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty book, extremes, cancels, unused mode, zero quantity
        send_order(CANCEL, BUY, 32'hFFFF_FFFF, 0, 0);
        send_order(MODE_SPARE, SELL, 32'h1234, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_order(LIMIT, BUY, 32'h1, 32'hFFFF_FFFF, 32'd0);
        send_order(MARKET, SELL, 32'h2, 0, 32'd5);
        send_order(LIMIT, SELL, 32'h3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_order(LIMIT, SELL, 32'h4, 32'd10, 32'd7);
        send_order(LIMIT, SELL, 32'h5, 32'd10, 32'd3);
        send_order(LIMIT, BUY, 32'h6, 32'd9, 32'd4);
        send_order(LIMIT, BUY, 32'h7, 32'd10, 32'd8);
        send_order(CANCEL, SELL, 32'h5, 0, 0);
        send_order(CANCEL, SELL, 32'h5, 0, 0);
        send_order(MARKET, BUY, 32'h8, 32'd0, 32'hFFFF_FFFF);
        send_order(LIMIT, BUY, 32'h0, 32'd0, 32'd1);
        // fill the book; the last buys find no free slot for their remainder
        for (int i = 0; i < 17; i++)
            send_order(LIMIT, BUY, 32'h20 + i, 32'd5, 32'd2);
        send_order(MARKET, SELL, 32'h40, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        settle();

        for (int ph = 0; ph < 3; ph++)
        begin
            in_idle = (ph == 0) ? 29 : (ph == 1) ? 75 : 0;
            out_idle = (ph == 0) ? 75 : (ph == 1) ? 29 : 0;
            for (int n = 0; n < 140; n++) random_order();
            settle();
        end

        $display("sent %0d orders, checked %0d result words across three idle phases",
                 sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Verification failed");
        $finish;
    end
endmodule
